[sv/sorted_list_insert_delete_core_defines.svh]
// Assertion macros for the sorted list core.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sli_pkg.sv]
// Shared types and codes for the sorted list core.
`timescale 1ns / 1ps
package sli_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_OUT
  } state_e;

endpackage

[sv/sli_if.sv]
// Command and result channel interfaces.
`timescale 1ns / 1ps
interface sli_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface sli_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         entry_count;
  logic signed [31:0] smallest_value;
  logic               store_empty;
  modport source (output valid, status, entry_count, smallest_value, store_empty,
                  input ready);
  modport sink   (input valid, status, entry_count, smallest_value, store_empty,
                  output ready);
endinterface

[sv/sli_mem.sv]
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module sli_mem #(
  parameter int Depth = 16,
  parameter int AW    = 4
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/sli_ctrl.sv]
// Sequencer: search, shift and result register around the entry memory.
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_core_defines.svh"
module sli_ctrl #(
  parameter int Capacity = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sli_cmd_if.sink            cmd_i,
  sli_res_if.source          res_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic signed [31:0] wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  logic signed [31:0] rdata_i
);
  import sli_pkg::*;

  localparam logic [CW-1:0] CapC = CW'(Capacity);

  state_e             state_q, state_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  status_e            stat_q, stat_d;
  logic signed [31:0] head_q, head_d;
  logic               ov_q, ov_d;
  status_e            ostat_q, ostat_d;
  logic [4:0]         ocnt_q, ocnt_d;
  logic signed [31:0] ohead_q, ohead_d;
  logic               oempty_q, oempty_d;
  logic [CW-1:0]      nxt, prv, raddr;
  logic               cmd_xfer;

  assign nxt      = idx_q + 1'b1;
  assign prv      = idx_q - 1'b1;
  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign raddr_o  = raddr[AW-1:0];

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    stat_d   = stat_q;
    head_d   = head_q;
    ov_d     = ov_q && !res_o.ready;
    ostat_d  = ostat_q;
    ocnt_d   = ocnt_q;
    ohead_d  = ohead_q;
    oempty_d = oempty_q;
    we_o     = 1'b0;
    waddr_o  = idx_q[AW-1:0];
    wdata_o  = val_q;
    raddr    = idx_q;
    cmd_i.ready = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (cmd_xfer) begin
          val_d  = cmd_i.value;
          stat_d = ST_DONE;
          if (cmd_i.command == CMD_INSERT) begin
            if (cnt_q == CapC) begin
              stat_d  = ST_FULL;
              state_d = S_HEAD_RD;
            end else if (cnt_q == '0) begin
              we_o    = 1'b1;
              waddr_o = '0;
              wdata_o = cmd_i.value;
              cnt_d   = cnt_q + 1'b1;
              state_d = S_HEAD_RD;
            end else begin
              idx_d   = cnt_q;
              state_d = S_INS_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              stat_d  = ST_NOT_FOUND;
              state_d = S_HEAD_RD;
            end else begin
              idx_d   = '0;
              state_d = S_DEL_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        raddr   = prv;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rdata_i < val_q) begin
          state_d = S_INS_PUT;
        end else begin
          we_o    = 1'b1;
          wdata_o = rdata_i;
          idx_d   = prv;
          state_d = (prv == '0) ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        we_o    = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_HEAD_RD;
      end
      S_DEL_RD: begin
        state_d = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (rdata_i == val_q) begin
          if (nxt < cnt_q) begin
            state_d = S_SH_RD;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = S_HEAD_RD;
          end
        end else if (nxt == cnt_q) begin
          stat_d  = ST_NOT_FOUND;
          state_d = S_HEAD_RD;
        end else begin
          idx_d   = nxt;
          state_d = S_DEL_RD;
        end
      end
      S_SH_RD: begin
        raddr   = nxt;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        idx_d   = nxt;
        if (nxt + 1'b1 < cnt_q) begin
          state_d = S_SH_RD;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        raddr   = '0;
        state_d = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        head_d  = (cnt_q == '0) ? 32'sd0 : rdata_i;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || res_o.ready) begin
          ov_d     = 1'b1;
          ostat_d  = stat_q;
          ocnt_d   = 5'(cnt_q);
          ohead_d  = head_q;
          oempty_d = (cnt_q == '0);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    idx_q    <= idx_d;
    stat_q   <= stat_d;
    head_q   <= head_d;
    ostat_q  <= ostat_d;
    ocnt_q   <= ocnt_d;
    ohead_q  <= ohead_d;
    oempty_q <= oempty_d;
  end

  assign res_o.valid          = ov_q;
  assign res_o.status         = ostat_q;
  assign res_o.entry_count    = ocnt_q;
  assign res_o.smallest_value = ohead_q;
  assign res_o.store_empty    = oempty_q;

  `SLI_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= CapC, "entry count above capacity")
  `SLI_ASSERT_NEXT(a_cnt_step, 1'b1,
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
    (cnt_q == $past(cnt_q) - 1'b1), "entry count moved by more than one")
  `SLI_ASSERT_NEXT(a_full_drop, cmd_xfer && cmd_i.command == CMD_INSERT && cnt_q == CapC,
    cnt_q == CapC && stat_q == ST_FULL, "insert into full store not dropped")
  `SLI_ASSERT_NOW(a_wr_range, we_o, idx_q < CapC || state_q == S_IDLE,
    "write beyond capacity")
endmodule

[sv/sorted_list_insert_delete_core.sv]
// Sorted list core top level.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a single
// memory with one write and one registered read port. Each command yields one
// result transfer. An insert reads entries from the tail and shifts up each one
// not below the new value until it reaches its sorted place; a delete searches
// from the head and shifts the later entries down. An insert into an empty
// store, a full insert or an empty delete needs no search. One command is in
// flight at a time; the result register lets the next command in while a
// result waits to be taken, and that command holds in its output step until
// the waiting result is taken.
`timescale 1ns / 1ps
module sorted_list_insert_delete_core #(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_cmd_if.sink   cmd_i,
  sli_res_if.source res_o
);
  import sli_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata, rdata;

  sli_ctrl #(.Capacity(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .res_o   (res_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  sli_mem #(.Depth(CAPACITY), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );
endmodule

[tb/sli_tb_if.sv]
// Interfaces note: the block's channel interfaces are in sv/sli_if.sv; this file holds tb helpers.
`timescale 1ns / 1ps
package sli_tb_pkg;
  import sli_pkg::*;
  localparam int TB_CAPACITY = 16;
endpackage

[tb/tb.sv]
// Testbench for the sorted list core: random and directed commands against a predictor.
`timescale 1ns / 1ps
module tb;
  import sli_pkg::*;
  import sli_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  sli_cmd_if cmd_if ();
  sli_res_if res_if ();

  sorted_list_insert_delete_core #(.CAPACITY(TB_CAPACITY)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  typedef struct packed {
    status_e            status;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest_value;
    logic               store_empty;
  } outcome_t;

  logic signed [31:0] shadow_list[$];
  outcome_t           pending_outcomes[$];
  int                 fail_count;
  bit                 hold_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic outcome_t predict_outcome(logic op, logic signed [31:0] v);
    outcome_t o;
    int pos;
    o.status = ST_DONE;
    if (op == CMD_INSERT) begin
      if (shadow_list.size() >= TB_CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
        shadow_list.insert(pos, v);
      end
    end else begin
      pos = 0;
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos >= shadow_list.size()) o.status = ST_NOT_FOUND;
      else shadow_list.delete(pos);
    end
    o.entry_count = 5'(shadow_list.size());
    o.store_empty = (shadow_list.size() == 0);
    o.smallest_value = o.store_empty ? 32'sd0 : shadow_list[0];
    return o;
  endfunction

  // valid stays high after a transfer; drain_results drops it, and so does the next call when it waits a random gap
  task automatic send_command(logic op, logic signed [31:0] v);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.command <= op;
    cmd_if.value <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_outcomes.push_back(predict_outcome(op, v));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    cmd_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int stall;
    res_if.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      while (hold_off) begin
        res_if.ready <= 1'b0;
        @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin
    outcome_t exp_o;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result transfer with no expectation");
          fail_count++;
        end else begin
          exp_o = pending_outcomes.pop_front();
          if (res_if.status !== exp_o.status) begin
            $error("status exp %0d got %0d", exp_o.status, res_if.status);
            fail_count++;
          end
          if (res_if.entry_count !== exp_o.entry_count) begin
            $error("entry_count exp %0d got %0d", exp_o.entry_count, res_if.entry_count);
            fail_count++;
          end
          if (res_if.smallest_value !== exp_o.smallest_value) begin
            $error("smallest_value exp %0d got %0d", exp_o.smallest_value,
                   res_if.smallest_value);
            fail_count++;
          end
          if (res_if.store_empty !== exp_o.store_empty) begin
            $error("store_empty exp %0d got %0d", exp_o.store_empty, res_if.store_empty);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7) - 4;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_command(CMD_DELETE, 32'sd5);
    send_command(CMD_INSERT, 32'sh7fffffff);
    send_command(CMD_INSERT, 32'sh80000000);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, -32'sd1);
    send_command(CMD_DELETE, 32'sd0);
    send_command(CMD_DELETE, 32'sd77);
    send_command(CMD_DELETE, 32'sh80000000);
    for (int i = 0; i < 14; i++) send_command(CMD_INSERT, 32'(i * 3 - 20));
    send_command(CMD_INSERT, 32'sd9);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) send_command(CMD_DELETE, pick_value());
      end
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain_results();
  endtask

  task automatic test_random();
    logic signed [31:0] v;
    for (int i = 0; i < 1250; i++) begin
      if (shadow_list.size() != 0 && $urandom_range(0, 2) != 0 && (i % 2) == 1) begin
        v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        send_command(CMD_DELETE, v);
      end else begin
        send_command($urandom_range(0, 2) == 0 ? CMD_DELETE : CMD_INSERT, pick_value());
      end
      if (i == 600) drain_results();
    end
    for (int i = 0; i < 20; i++) send_command(CMD_INSERT, $urandom);
    while (shadow_list.size() != 0) send_command(CMD_DELETE, shadow_list[0]);
    drain_results();
  endtask

  initial begin
    #20_000_000;
    $display("[sorted_list_insert_delete_core] ERROR");
    $finish;
  end

  initial begin
    fail_count = 0;
    hold_off = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_INSERT;
    cmd_if.value = '0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("[sorted_list_insert_delete_core] OK");
    end else begin
      $display("[sorted_list_insert_delete_core] ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/sli_pkg.sv
sv/sli_if.sv
sv/sli_mem.sv
sv/sli_ctrl.sv
sv/sorted_list_insert_delete_core.sv
tb/sli_tb_if.sv
tb/tb.sv
